// ===== src/mssrc_pkg.sv =====
// ----------------------------------------------------------------------------
// Motor soft-start ramp controller package
// Shared types and fixed constants for the ramp controller and its step logic.
// ----------------------------------------------------------------------------
package mssrc_pkg;

  localparam int RPM_W     = 16;
  localparam int SCALE_W   = 16;
  localparam int PROD_W    = RPM_W + SCALE_W;
  localparam int FRAC_BITS = 8;
  localparam int CONV_W    = PROD_W + 1 - FRAC_BITS;
  localparam int CFG_IDX_W = 3;

  localparam int MIN_RPM_RST    = 100;
  localparam int MAX_RPM_RST    = 20000;
  localparam int MIN_FREQ_RST   = 100;
  localparam int MAX_FREQ_RST   = 20000;
  localparam int START_FREQ_RST = 100;
  localparam int RAMP_STEP_RST  = 50;
  localparam int HZ_PER_RPM_RST = 256;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_SPEED = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RES_OK        = 2'd0,
    RES_BAD_ARG   = 2'd1,
    RES_BAD_STATE = 2'd2
  } res_t;

  typedef enum logic [2:0] {
    ST_DISABLED = 3'd0,
    ST_STARTING = 3'd1,
    ST_RUNNING  = 3'd2,
    ST_RAMPING  = 3'd3,
    ST_STOPPING = 3'd4,
    ST_FAULT    = 3'd5
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_RPM    = 3'd0,
    CFG_MAX_RPM    = 3'd1,
    CFG_MIN_FREQ   = 3'd2,
    CFG_MAX_FREQ   = 3'd3,
    CFG_START_FREQ = 3'd4,
    CFG_RAMP_STEP  = 3'd5,
    CFG_HZ_PER_RPM = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    mode_t mode;
    logic  pfm;
    logic  motor;
  } ctl_t;

  typedef struct packed {
    res_t res;
    logic fwrite;
    logic fentered;
  } flags_t;

endpackage

// ===== src/mssrc_step.sv =====
// ----------------------------------------------------------------------------
// Ramp controller step logic
// Computes the next motor state and the result flags for one registered item.
// ----------------------------------------------------------------------------
module mssrc_step #(
  parameter int FREQ_BITS = 20
) (
  input  mssrc_pkg::op_t                     op,
  input  logic                               fail,
  input  logic                               rpm_ok,
  input  logic [mssrc_pkg::PROD_W-1:0]       prod,
  input  logic [FREQ_BITS-1:0]               min_freq,
  input  logic [FREQ_BITS-1:0]               max_freq,
  input  logic [FREQ_BITS-1:0]               start_freq,
  input  logic [FREQ_BITS-1:0]               ramp_step,
  input  mssrc_pkg::ctl_t                    ctl_cur,
  input  logic [FREQ_BITS-1:0]               now_cur,
  input  logic [FREQ_BITS-1:0]               goal_cur,
  output mssrc_pkg::ctl_t                    ctl_nxt,
  output logic [FREQ_BITS-1:0]               now_nxt,
  output logic [FREQ_BITS-1:0]               goal_nxt,
  output mssrc_pkg::flags_t                  flags
);

  localparam int CW = (FREQ_BITS > mssrc_pkg::CONV_W) ? FREQ_BITS : mssrc_pkg::CONV_W;
  localparam logic [mssrc_pkg::PROD_W:0] ROUND_HALF =
    (mssrc_pkg::PROD_W + 1)'(1) << (mssrc_pkg::FRAC_BITS - 1);

  logic [mssrc_pkg::PROD_W:0]   sum;
  logic [mssrc_pkg::CONV_W-1:0] conv;
  logic                         freq_ok;
  logic                         up;
  logic [FREQ_BITS-1:0]         diff_hz;
  logic [FREQ_BITS-1:0]         ramp_hz;

  assign sum     = {1'b0, prod} + ROUND_HALF;
  assign conv    = sum[mssrc_pkg::PROD_W:mssrc_pkg::FRAC_BITS];
  assign freq_ok = (CW'(conv) >= CW'(min_freq)) && (CW'(conv) <= CW'(max_freq));

  assign up      = now_cur < goal_cur;
  assign diff_hz = up ? (goal_cur - now_cur) : (now_cur - goal_cur);
  assign ramp_hz = (diff_hz < ramp_step) ? goal_cur :
                   (up ? (now_cur + ramp_step) : (now_cur - ramp_step));

  always_comb begin
    ctl_nxt  = ctl_cur;
    now_nxt  = now_cur;
    goal_nxt = goal_cur;
    flags    = '{res: mssrc_pkg::RES_OK, fwrite: 1'b0, fentered: 1'b0};
    case (op)
      mssrc_pkg::OP_START: begin
        if (ctl_cur.mode == mssrc_pkg::ST_DISABLED) begin
          ctl_nxt.mode = mssrc_pkg::ST_STARTING;
        end else if (ctl_cur.mode == mssrc_pkg::ST_STOPPING ||
                     ctl_cur.mode == mssrc_pkg::ST_FAULT) begin
          flags.res = mssrc_pkg::RES_BAD_STATE;
        end
      end
      mssrc_pkg::OP_STOP: begin
        if (ctl_cur.mode == mssrc_pkg::ST_FAULT) begin
          flags.res = mssrc_pkg::RES_BAD_STATE;
        end else if (ctl_cur.mode == mssrc_pkg::ST_STARTING ||
                     ctl_cur.mode == mssrc_pkg::ST_RUNNING ||
                     ctl_cur.mode == mssrc_pkg::ST_RAMPING) begin
          goal_nxt     = min_freq;
          ctl_nxt.mode = mssrc_pkg::ST_STOPPING;
        end
      end
      mssrc_pkg::OP_SPEED: begin
        if (!rpm_ok) begin
          flags.res = mssrc_pkg::RES_BAD_ARG;
        end else if (ctl_cur.mode == mssrc_pkg::ST_STOPPING) begin
          flags.res = mssrc_pkg::RES_OK;
        end else if (ctl_cur.mode == mssrc_pkg::ST_FAULT) begin
          flags.res = mssrc_pkg::RES_BAD_STATE;
        end else if (!freq_ok) begin
          flags.res = mssrc_pkg::RES_BAD_ARG;
        end else begin
          goal_nxt = FREQ_BITS'(conv);
          if (ctl_cur.mode == mssrc_pkg::ST_RUNNING) begin
            ctl_nxt.mode = mssrc_pkg::ST_RAMPING;
          end
        end
      end
      mssrc_pkg::OP_TICK: begin
        case (ctl_cur.mode)
          mssrc_pkg::ST_STARTING: begin
            if (fail) begin
              ctl_nxt        = '{mode: mssrc_pkg::ST_FAULT, pfm: 1'b0, motor: 1'b0};
              flags.fentered = 1'b1;
            end else begin
              now_nxt      = start_freq;
              ctl_nxt.pfm  = 1'b1;
              ctl_nxt.motor = 1'b1;
              flags.fwrite = 1'b1;
              ctl_nxt.mode = (start_freq != goal_cur) ? mssrc_pkg::ST_RAMPING :
                                                        mssrc_pkg::ST_RUNNING;
            end
          end
          mssrc_pkg::ST_STOPPING: begin
            if (!ctl_cur.motor && !ctl_cur.pfm) begin
              now_nxt      = '0;
              goal_nxt     = min_freq;
              ctl_nxt.mode = mssrc_pkg::ST_DISABLED;
            end else if (fail) begin
              ctl_nxt        = '{mode: mssrc_pkg::ST_FAULT, pfm: 1'b0, motor: 1'b0};
              flags.fentered = 1'b1;
            end else if (now_cur != goal_cur) begin
              now_nxt      = ramp_hz;
              flags.fwrite = 1'b1;
            end else begin
              ctl_nxt  = '{mode: mssrc_pkg::ST_DISABLED, pfm: 1'b0, motor: 1'b0};
              now_nxt  = '0;
              goal_nxt = min_freq;
            end
          end
          mssrc_pkg::ST_RUNNING, mssrc_pkg::ST_RAMPING: begin
            if (now_cur == goal_cur) begin
              ctl_nxt.mode = mssrc_pkg::ST_RUNNING;
            end else if (fail) begin
              ctl_nxt        = '{mode: mssrc_pkg::ST_FAULT, pfm: 1'b0, motor: 1'b0};
              flags.fentered = 1'b1;
            end else begin
              now_nxt      = ramp_hz;
              flags.fwrite = 1'b1;
              ctl_nxt.mode = (ramp_hz == goal_cur) ? mssrc_pkg::ST_RUNNING :
                                                     mssrc_pkg::ST_RAMPING;
            end
          end
          default: begin
            ctl_nxt = ctl_cur;
          end
        endcase
      end
      default: begin
        ctl_nxt = ctl_cur;
      end
    endcase
  end

endmodule

// ===== src/motor_soft_start_ramp_controller.sv =====
// ----------------------------------------------------------------------------
// Motor soft-start ramp controller
// Start, stop, speed and ramp-tick handling with a six-state motor status.
//
//   channel  handshake           payload
//   in       in_valid/in_stall   opcode, speed_rpm, driver_fail
//   out      out_valid/out_stall cmd_result, status, frequencies, marks, flags
//   cfg      cfg_we              cfg_index, cfg_wdata
//
// One transfer per cycle in each direction while neither side stalls. A result is
// loaded into the result register when its input stage advances, then transfers from there.
// The rpm scale multiply sits in the input stage, the state update in the second.
// Reset is synchronous and restores the register defaults and the disabled state.
// A stalled result holds; the input stage keeps accepting while it can move on.
// ----------------------------------------------------------------------------
module motor_soft_start_ramp_controller #(
  parameter int FREQ_BITS = 20
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_we,
  input  logic [mssrc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [((FREQ_BITS > 16) ? FREQ_BITS : 16)-1:0] cfg_wdata,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [1:0]                              in_opcode,
  input  logic [15:0]                             in_speed_rpm,
  input  logic                                    in_driver_fail,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [1:0]                              out_cmd_result,
  output logic [2:0]                              out_status,
  output logic [FREQ_BITS-1:0]                    out_current_hz,
  output logic [FREQ_BITS-1:0]                    out_target_hz,
  output logic                                    out_pfm_on,
  output logic                                    out_motor_on,
  output logic                                    out_freq_write,
  output logic                                    out_fault_entered
);

  logic [mssrc_pkg::RPM_W-1:0]   min_rpm_r;
  logic [mssrc_pkg::RPM_W-1:0]   max_rpm_r;
  logic [FREQ_BITS-1:0]          min_freq_r;
  logic [FREQ_BITS-1:0]          max_freq_r;
  logic [FREQ_BITS-1:0]          start_freq_r;
  logic [FREQ_BITS-1:0]          ramp_step_r;
  logic [mssrc_pkg::SCALE_W-1:0] hz_per_rpm_r;

  logic                          s1_valid_r;
  mssrc_pkg::op_t                s1_op_r;
  logic                          s1_fail_r;
  logic                          s1_rpm_ok_r;
  logic [mssrc_pkg::PROD_W-1:0]  s1_prod_r;

  mssrc_pkg::ctl_t               ctl_r;
  logic [FREQ_BITS-1:0]          now_r;
  logic [FREQ_BITS-1:0]          goal_r;
  logic                          out_valid_r;
  mssrc_pkg::res_t               out_res_r;
  logic                          out_fwrite_r;
  logic                          out_fentered_r;

  mssrc_pkg::ctl_t               ctl_nxt;
  logic [FREQ_BITS-1:0]          now_nxt;
  logic [FREQ_BITS-1:0]          goal_nxt;
  mssrc_pkg::flags_t             flags_nxt;

  logic                          in_acc;
  logic                          out_acc;
  logic                          adv;
  logic                          rpm_ok;
  logic [mssrc_pkg::PROD_W-1:0]  prod;

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;

  assign rpm_ok = (in_speed_rpm >= min_rpm_r) && (in_speed_rpm <= max_rpm_r);
  assign prod   = mssrc_pkg::PROD_W'(in_speed_rpm) * mssrc_pkg::PROD_W'(hz_per_rpm_r);

  mssrc_step #(
    .FREQ_BITS(FREQ_BITS)
  ) u_step (
    .op        (s1_op_r),
    .fail      (s1_fail_r),
    .rpm_ok    (s1_rpm_ok_r),
    .prod      (s1_prod_r),
    .min_freq  (min_freq_r),
    .max_freq  (max_freq_r),
    .start_freq(start_freq_r),
    .ramp_step (ramp_step_r),
    .ctl_cur   (ctl_r),
    .now_cur   (now_r),
    .goal_cur  (goal_r),
    .ctl_nxt   (ctl_nxt),
    .now_nxt   (now_nxt),
    .goal_nxt  (goal_nxt),
    .flags     (flags_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_rpm_r    <= mssrc_pkg::RPM_W'(mssrc_pkg::MIN_RPM_RST);
      max_rpm_r    <= mssrc_pkg::RPM_W'(mssrc_pkg::MAX_RPM_RST);
      min_freq_r   <= FREQ_BITS'(mssrc_pkg::MIN_FREQ_RST);
      max_freq_r   <= FREQ_BITS'(mssrc_pkg::MAX_FREQ_RST);
      start_freq_r <= FREQ_BITS'(mssrc_pkg::START_FREQ_RST);
      ramp_step_r  <= FREQ_BITS'(mssrc_pkg::RAMP_STEP_RST);
      hz_per_rpm_r <= mssrc_pkg::SCALE_W'(mssrc_pkg::HZ_PER_RPM_RST);
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      ctl_r        <= '{mode: mssrc_pkg::ST_DISABLED, pfm: 1'b0, motor: 1'b0};
      now_r        <= '0;
      goal_r       <= FREQ_BITS'(mssrc_pkg::MIN_FREQ_RST);
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mssrc_pkg::CFG_MIN_RPM:    min_rpm_r    <= cfg_wdata[mssrc_pkg::RPM_W-1:0];
          mssrc_pkg::CFG_MAX_RPM:    max_rpm_r    <= cfg_wdata[mssrc_pkg::RPM_W-1:0];
          mssrc_pkg::CFG_MIN_FREQ:   min_freq_r   <= cfg_wdata[FREQ_BITS-1:0];
          mssrc_pkg::CFG_MAX_FREQ:   max_freq_r   <= cfg_wdata[FREQ_BITS-1:0];
          mssrc_pkg::CFG_START_FREQ: start_freq_r <= cfg_wdata[FREQ_BITS-1:0];
          mssrc_pkg::CFG_RAMP_STEP:  ramp_step_r  <= cfg_wdata[FREQ_BITS-1:0];
          mssrc_pkg::CFG_HZ_PER_RPM: hz_per_rpm_r <= cfg_wdata[mssrc_pkg::SCALE_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        s1_valid_r  <= 1'b1;
        s1_op_r     <= mssrc_pkg::op_t'(in_opcode);
        s1_fail_r   <= in_driver_fail;
        s1_rpm_ok_r <= rpm_ok;
        s1_prod_r   <= prod;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        ctl_r          <= ctl_nxt;
        now_r          <= now_nxt;
        goal_r         <= goal_nxt;
        out_valid_r    <= 1'b1;
        out_res_r      <= flags_nxt.res;
        out_fwrite_r   <= flags_nxt.fwrite;
        out_fentered_r <= flags_nxt.fentered;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cmd_result    = out_res_r;
  assign out_status        = ctl_r.mode;
  assign out_current_hz    = now_r;
  assign out_target_hz     = goal_r;
  assign out_pfm_on        = ctl_r.pfm;
  assign out_motor_on      = ctl_r.motor;
  assign out_freq_write    = out_fwrite_r;
  assign out_fault_entered = out_fentered_r;

`ifndef ASSERT_OFF
  a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.mode == mssrc_pkg::ST_FAULT |=> ctl_r.mode == mssrc_pkg::ST_FAULT)
    else $error("fault state was left without reset");

  a_fault_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fentered_r |-> ctl_r.mode == mssrc_pkg::ST_FAULT && !ctl_r.motor)
    else $error("fault entry reported outside the fault state");

  a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.mode == mssrc_pkg::ST_DISABLED |-> now_r == '0)
    else $error("disabled motor holds a nonzero frequency");

  a_write_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fwrite_r |-> ctl_r.pfm && ctl_r.motor)
    else $error("frequency written while the motor is not enabled");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("advanced item produced no result");
`endif

endmodule

// ===== tb/tb_motor_soft_start_ramp_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor soft-start ramp controller testbench
// Drives start, stop, set-speed and ramp-tick transfers with random gaps and
// result stalls. Results are compared with an in-bench model of the status
// machine or typed script values. The run starts with a short scripted sequence at the reset
// register values, then uses several fixed and random register settings. It
// ends with a single driver failure, because the fault state is sticky until
// reset.
// ----------------------------------------------------------------------------
module tb_motor_soft_start_ramp_controller;
  import mssrc_pkg::*;

  localparam int FB         = 20;
  localparam int CFG_W      = (FB > 16) ? FB : 16;
  localparam int NUM_REGS   = 7;
  localparam int IDLE_LIMIT = 3000;
  localparam int SCRIPT_LEN = 28;

  typedef struct packed {
    res_t          res;
    mode_t         status;
    logic [FB-1:0] cur_hz;
    logic [FB-1:0] tgt_hz;
    logic          pfm;
    logic          motor;
    logic          fwrite;
    logic          fentered;
  } motor_report_t;

  typedef struct packed {
    op_t           op;
    logic [15:0]   rpm;
    logic          fail;
    logic          fixed;
    motor_report_t want;
  } script_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_opcode = '0;
  logic [15:0]          in_speed_rpm = '0;
  logic                 in_driver_fail = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_cmd_result;
  logic [2:0]           out_status;
  logic [FB-1:0]        out_current_hz;
  logic [FB-1:0]        out_target_hz;
  logic                 out_pfm_on;
  logic                 out_motor_on;
  logic                 out_freq_write;
  logic                 out_fault_entered;

  motor_soft_start_ramp_controller #(.FREQ_BITS(FB)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_opcode(in_opcode),
    .in_speed_rpm(in_speed_rpm),
    .in_driver_fail(in_driver_fail),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_cmd_result(out_cmd_result),
    .out_status(out_status),
    .out_current_hz(out_current_hz),
    .out_target_hz(out_target_hz),
    .out_pfm_on(out_pfm_on),
    .out_motor_on(out_motor_on),
    .out_freq_write(out_freq_write),
    .out_fault_entered(out_fault_entered)
  );

  always #5 clk = ~clk;

  // Register shadow and motor state of the in-bench model.
  logic [CFG_W-1:0] reg_val  [NUM_REGS];
  int unsigned      reg_plan [NUM_REGS];
  mode_t            m_mode;
  logic [FB-1:0]    m_now;
  logic [FB-1:0]    m_goal;
  logic             m_pfm;
  logic             m_en;

  motor_report_t motor_reports[$];
  script_row_t   script [SCRIPT_LEN];

  int mismatches   = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int settings     = 1;
  int idle_cycles  = 0;
  int nogap_left   = 0;
  int stall_hold   = 0;

  function automatic logic [FB-1:0] ramp_toward();
    logic [FB-1:0] gap_hz;
    logic [FB-1:0] step;
    step = reg_val[CFG_RAMP_STEP][FB-1:0];
    if (m_now < m_goal) begin
      gap_hz = m_goal - m_now;
      return m_now + ((gap_hz < step) ? gap_hz : step);
    end
    gap_hz = m_now - m_goal;
    return m_now - ((gap_hz < step) ? gap_hz : step);
  endfunction

  function automatic motor_report_t advance_motor(op_t op, logic [15:0] rpm, logic fail);
    motor_report_t rep;
    res_t          res;
    logic          wr;
    logic          fe;
    logic          to_idle;
    logic [32:0]   scaled;
    res = RES_OK;
    wr = 1'b0;
    fe = 1'b0;
    to_idle = 1'b0;
    case (op)
      OP_START: begin
        if (m_mode == ST_DISABLED) m_mode = ST_STARTING;
        else if (m_mode == ST_STOPPING || m_mode == ST_FAULT) res = RES_BAD_STATE;
      end
      OP_STOP: begin
        if (m_mode == ST_FAULT) begin
          res = RES_BAD_STATE;
        end else if (m_mode == ST_STARTING || m_mode == ST_RUNNING ||
                     m_mode == ST_RAMPING) begin
          m_goal = reg_val[CFG_MIN_FREQ][FB-1:0];
          m_mode = ST_STOPPING;
        end
      end
      OP_SPEED: begin
        if (rpm < reg_val[CFG_MIN_RPM] || rpm > reg_val[CFG_MAX_RPM]) begin
          res = RES_BAD_ARG;
        end else if (m_mode == ST_FAULT) begin
          res = RES_BAD_STATE;
        end else if (m_mode != ST_STOPPING) begin
          scaled = ({17'd0, rpm} * {17'd0, reg_val[CFG_HZ_PER_RPM][15:0]} + 33'd128) >> 8;
          if (scaled < reg_val[CFG_MIN_FREQ] || scaled > reg_val[CFG_MAX_FREQ]) begin
            res = RES_BAD_ARG;
          end else begin
            m_goal = scaled[FB-1:0];
            if (m_mode == ST_RUNNING) m_mode = ST_RAMPING;
          end
        end
      end
      default: begin
        case (m_mode)
          ST_STARTING: begin
            if (fail) begin
              fe = 1'b1;
            end else begin
              m_now = reg_val[CFG_START_FREQ][FB-1:0];
              m_pfm = 1'b1;
              m_en = 1'b1;
              wr = 1'b1;
              m_mode = (m_now != m_goal) ? ST_RAMPING : ST_RUNNING;
            end
          end
          ST_STOPPING: begin
            if (!m_en && !m_pfm) begin
              to_idle = 1'b1;
            end else if (fail) begin
              fe = 1'b1;
            end else if (m_now != m_goal) begin
              m_now = ramp_toward();
              wr = 1'b1;
            end else begin
              m_pfm = 1'b0;
              m_en = 1'b0;
              to_idle = 1'b1;
            end
          end
          ST_RUNNING, ST_RAMPING: begin
            if (m_now != m_goal) begin
              if (fail) fe = 1'b1;
              else begin
                m_now = ramp_toward();
                wr = 1'b1;
              end
            end
            if (!fe) m_mode = (m_now == m_goal) ? ST_RUNNING : ST_RAMPING;
          end
          default: ;
        endcase
      end
    endcase
    if (fe) begin
      m_pfm = 1'b0;
      m_en = 1'b0;
      m_mode = ST_FAULT;
    end
    if (to_idle) begin
      m_now = '0;
      m_goal = reg_val[CFG_MIN_FREQ][FB-1:0];
      m_mode = ST_DISABLED;
    end
    rep.res = res;
    rep.status = m_mode;
    rep.cur_hz = m_now;
    rep.tgt_hz = m_goal;
    rep.pfm = m_pfm;
    rep.motor = m_en;
    rep.fwrite = wr;
    rep.fentered = fe;
    return rep;
  endfunction

  task automatic send_item(op_t op, logic [15:0] rpm, logic fail, logic fixed,
                           motor_report_t typed);
    int gap;
    int pct;
    motor_report_t want;
    pct = $urandom_range(0, 99);
    if (nogap_left > 0) begin
      gap = 0;
      nogap_left--;
    end else if (pct < 3) begin
      gap = 0;
      nogap_left = $urandom_range(20, 50);
    end else if (pct < 50) gap = 0;
    else if (pct < 85) gap = $urandom_range(1, 3);
    else if (pct < 95) gap = $urandom_range(4, 10);
    else gap = $urandom_range(15, 40);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_speed_rpm <= rpm;
    in_driver_fail <= fail;
    do @(posedge clk); while (in_stall);
    want = advance_motor(op, rpm, fail);
    motor_reports.push_back(fixed ? typed : want);
    items_sent++;
  endtask

  // Registers are only written once every expected result has come back.
  task automatic load_config();
    in_valid <= 1'b0;
    while (motor_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_wdata <= CFG_W'(reg_plan[i]);
      reg_val[i] = CFG_W'(reg_plan[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic run_random(int count);
    int   pct;
    op_t  op;
    logic [15:0] rpm;
    logic fail;
    logic passive;
    for (int n = 0; n < count; n++) begin
      pct = $urandom_range(0, 99);
      case (m_mode)
        ST_DISABLED: op = (pct < 40) ? OP_START : (pct < 70) ? OP_SPEED :
                          (pct < 90) ? OP_TICK : OP_STOP;
        ST_STARTING: op = (pct < 60) ? OP_TICK : (pct < 80) ? OP_SPEED :
                          (pct < 90) ? OP_STOP : OP_START;
        ST_STOPPING: op = (pct < 75) ? OP_TICK : (pct < 85) ? OP_SPEED :
                          (pct < 93) ? OP_START : OP_STOP;
        default:     op = (pct < 65) ? OP_TICK : (pct < 85) ? OP_SPEED :
                          (pct < 95) ? OP_STOP : OP_START;
      endcase
      if ($urandom_range(0, 99) < 8) op = op_t'($urandom_range(0, 3));
      pct = $urandom_range(0, 99);
      if (pct < 15) rpm = reg_val[CFG_MIN_RPM][15:0];
      else if (pct < 30) rpm = reg_val[CFG_MAX_RPM][15:0];
      else if (pct < 38) rpm = reg_val[CFG_MIN_RPM][15:0] - 16'd1;
      else if (pct < 46) rpm = reg_val[CFG_MAX_RPM][15:0] + 16'd1;
      else if (pct < 85 && reg_val[CFG_MIN_RPM] <= reg_val[CFG_MAX_RPM])
        rpm = 16'($urandom_range(reg_val[CFG_MIN_RPM], reg_val[CFG_MAX_RPM]));
      else rpm = 16'($urandom_range(0, 65535));
      // A failing driver action is allowed only where the tick performs none.
      passive = (m_mode == ST_DISABLED) || (m_mode == ST_FAULT) ||
                ((m_mode == ST_RUNNING || m_mode == ST_RAMPING) && m_now == m_goal) ||
                (m_mode == ST_STOPPING && !m_en && !m_pfm);
      fail = (op != OP_TICK || passive) ? 1'($urandom_range(0, 1)) : 1'b0;
      send_item(op, rpm, fail, 1'b0, '0);
    end
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    motor_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (motor_reports.size() == 0) begin
        $error("result transfer with no expectation waiting");
        mismatches++;
      end else begin
        want = motor_reports.pop_front();
        check_field("cmd_result", want.res, out_cmd_result);
        check_field("status", want.status, out_status);
        check_field("current_hz", want.cur_hz, out_current_hz);
        check_field("target_hz", want.tgt_hz, out_target_hz);
        check_field("pfm_on", want.pfm, out_pfm_on);
        check_field("motor_on", want.motor, out_motor_on);
        check_field("freq_write", want.fwrite, out_freq_write);
        check_field("fault_entered", want.fentered, out_fault_entered);
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:54]: begin
          out_stall <= 1'b0;
          stall_hold <= $urandom_range(0, 6);
        end
        [55:89]: begin
          out_stall <= 1'b1;
          stall_hold <= $urandom_range(0, 3);
        end
        [90:96]: begin
          out_stall <= 1'b1;
          stall_hold <= $urandom_range(8, 40);
        end
        default: begin
          out_stall <= 1'b0;
          stall_hold <= $urandom_range(60, 200);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("FAIL motor_soft_start_ramp_controller");
      $finish;
    end
  end

  initial begin
    int    fault_path;
    int    pct;
    string path_name;
    reg_val[CFG_MIN_RPM]    = CFG_W'(MIN_RPM_RST);
    reg_val[CFG_MAX_RPM]    = CFG_W'(MAX_RPM_RST);
    reg_val[CFG_MIN_FREQ]   = CFG_W'(MIN_FREQ_RST);
    reg_val[CFG_MAX_FREQ]   = CFG_W'(MAX_FREQ_RST);
    reg_val[CFG_START_FREQ] = CFG_W'(START_FREQ_RST);
    reg_val[CFG_RAMP_STEP]  = CFG_W'(RAMP_STEP_RST);
    reg_val[CFG_HZ_PER_RPM] = CFG_W'(HZ_PER_RPM_RST);
    m_mode = ST_DISABLED;
    m_now = '0;
    m_goal = FB'(MIN_FREQ_RST);
    m_pfm = 1'b0;
    m_en = 1'b0;

    script = '{
      '{OP_TICK,  16'd0,     1'b1, 1'b1,
        '{RES_OK, ST_DISABLED, 20'd0, 20'd100, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{OP_STOP,  16'd0,     1'b0, 1'b1,
        '{RES_OK, ST_DISABLED, 20'd0, 20'd100, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{OP_SPEED, 16'd0,     1'b0, 1'b1,
        '{RES_BAD_ARG, ST_DISABLED, 20'd0, 20'd100, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{OP_SPEED, 16'd65535, 1'b1, 1'b1,
        '{RES_BAD_ARG, ST_DISABLED, 20'd0, 20'd100, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{OP_SPEED, 16'd99,    1'b0, 1'b1,
        '{RES_BAD_ARG, ST_DISABLED, 20'd0, 20'd100, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{OP_SPEED, 16'd300,   1'b0, 1'b1,
        '{RES_OK, ST_DISABLED, 20'd0, 20'd300, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{OP_START, 16'd0,     1'b1, 1'b1,
        '{RES_OK, ST_STARTING, 20'd0, 20'd300, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{OP_TICK,  16'd0,     1'b0, 1'b1,
        '{RES_OK, ST_RAMPING, 20'd100, 20'd300, 1'b1, 1'b1, 1'b1, 1'b0}},
      '{OP_TICK,  16'd0,     1'b0, 1'b0, '0},
      '{OP_TICK,  16'd0,     1'b0, 1'b0, '0},
      '{OP_TICK,  16'd0,     1'b0, 1'b0, '0},
      '{OP_TICK,  16'd0,     1'b0, 1'b0, '0},
      '{OP_TICK,  16'd0,     1'b1, 1'b0, '0},
      '{OP_SPEED, 16'd20000, 1'b0, 1'b0, '0},
      '{OP_SPEED, 16'd100,   1'b0, 1'b0, '0},
      '{OP_TICK,  16'd0,     1'b0, 1'b0, '0},
      '{OP_STOP,  16'd0,     1'b0, 1'b0, '0},
      '{OP_SPEED, 16'd500,   1'b0, 1'b0, '0},
      '{OP_SPEED, 16'd50,    1'b0, 1'b0, '0},
      '{OP_START, 16'd0,     1'b0, 1'b1,
        '{RES_BAD_STATE, ST_STOPPING, 20'd250, 20'd100, 1'b1, 1'b1, 1'b0, 1'b0}},
      '{OP_TICK,  16'd0,     1'b0, 1'b0, '0},
      '{OP_TICK,  16'd0,     1'b0, 1'b0, '0},
      '{OP_TICK,  16'd0,     1'b0, 1'b0, '0},
      '{OP_TICK,  16'd0,     1'b0, 1'b0, '0},
      '{OP_START, 16'd0,     1'b0, 1'b0, '0},
      '{OP_SPEED, 16'd400,   1'b0, 1'b0, '0},
      '{OP_STOP,  16'd0,     1'b0, 1'b0, '0},
      '{OP_TICK,  16'd0,     1'b1, 1'b0, '0}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i])
      send_item(script[i].op, script[i].rpm, script[i].fail, script[i].fixed, script[i].want);

    // Fixed settings: full-range extremes, half-up rounding with a start at the
    // top of the range, a narrow band with single-hertz steps, and a zero step.
    reg_plan = '{0, 65535, 0, 1048575, 0, 1048575, 65535};
    load_config();
    run_random(70);
    reg_plan = '{1, 4000, 0, 1048575, 1048575, 3000, 128};
    load_config();
    run_random(70);
    reg_plan = '{10, 60, 5, 40, 20, 1, 256};
    load_config();
    run_random(70);
    reg_plan = '{100, 20000, 100, 20000, 100, 0, 256};
    load_config();
    run_random(20);

    for (int p = 0; p < 6; p++) begin
      pct = $urandom_range(0, 99);
      reg_plan[CFG_MIN_RPM] = (pct < 10) ? 65535 : (pct < 30) ? 0 : $urandom_range(0, 3000);
      if (reg_plan[CFG_MIN_RPM] == 65535 || $urandom_range(0, 99) < 15) begin
        reg_plan[CFG_MAX_RPM] = 65535;
      end else begin
        pct = $urandom_range(0, 30000);
        reg_plan[CFG_MAX_RPM] = (reg_plan[CFG_MIN_RPM] + pct > 65535) ? 65535 :
                                reg_plan[CFG_MIN_RPM] + pct;
      end
      case ($urandom_range(0, 7))
        0: reg_plan[CFG_HZ_PER_RPM] = 0;
        1: reg_plan[CFG_HZ_PER_RPM] = 1;
        2: reg_plan[CFG_HZ_PER_RPM] = 128;
        3: reg_plan[CFG_HZ_PER_RPM] = 255;
        4: reg_plan[CFG_HZ_PER_RPM] = 256;
        5: reg_plan[CFG_HZ_PER_RPM] = 257;
        6: reg_plan[CFG_HZ_PER_RPM] = 65535;
        default: reg_plan[CFG_HZ_PER_RPM] = $urandom_range(0, 65535);
      endcase
      reg_plan[CFG_MIN_FREQ] = ($urandom_range(0, 99) < 40) ? 0 : $urandom_range(1, 2000);
      reg_plan[CFG_MAX_FREQ] = ($urandom_range(0, 99) < 30) ? 1048575 :
                               reg_plan[CFG_MIN_FREQ] + $urandom_range(0, 200000);
      case ($urandom_range(0, 3))
        0: reg_plan[CFG_START_FREQ] = 0;
        1: reg_plan[CFG_START_FREQ] = reg_plan[CFG_MIN_FREQ];
        2: reg_plan[CFG_START_FREQ] = 1048575;
        default: reg_plan[CFG_START_FREQ] = $urandom_range(0, reg_plan[CFG_MAX_FREQ]);
      endcase
      case ($urandom_range(0, 3))
        0: reg_plan[CFG_RAMP_STEP] = 1;
        1: reg_plan[CFG_RAMP_STEP] = 1048575;
        2: reg_plan[CFG_RAMP_STEP] = $urandom_range(1, 200);
        default: reg_plan[CFG_RAMP_STEP] = $urandom_range(200, 60000);
      endcase
      load_config();
      run_random(65);
    end

    // Bring the motor back to disabled with a one-tick ramp, then restore the
    // reset values for the single fault entry of the run.
    reg_plan = '{100, 20000, 100, 20000, 100, 1048575, 256};
    load_config();
    while (m_mode != ST_DISABLED) begin
      if (m_mode == ST_STOPPING) send_item(OP_TICK, 16'd0, 1'b0, 1'b0, '0);
      else send_item(OP_STOP, 16'd0, 1'b0, 1'b0, '0);
    end
    reg_plan = '{100, 20000, 100, 20000, 100, 50, 256};
    load_config();
    send_item(OP_SPEED, 16'd300, 1'b0, 1'b0, '0);
    send_item(OP_START, 16'd0, 1'b0, 1'b0, '0);
    fault_path = $urandom_range(0, 3);
    case (fault_path)
      0: path_name = "start write";
      1: path_name = "ramp write";
      2: path_name = "PFM disable on stop";
      default: path_name = "ramp write while stopping";
    endcase
    if (fault_path != 0) send_item(OP_TICK, 16'd0, 1'b0, 1'b0, '0);
    if (fault_path == 2) send_item(OP_STOP, 16'd0, 1'b0, 1'b0, '0);
    if (fault_path == 3) begin
      send_item(OP_TICK, 16'd0, 1'b0, 1'b0, '0);
      send_item(OP_STOP, 16'd0, 1'b0, 1'b0, '0);
    end
    send_item(OP_TICK, 16'd0, 1'b1, 1'b0, '0);
    send_item(OP_SPEED, 16'd0, 1'b0, 1'b0, '0);
    send_item(OP_SPEED, 16'd300, 1'b1, 1'b0, '0);
    send_item(OP_START, 16'd0, 1'b0, 1'b0, '0);
    send_item(OP_STOP, 16'd0, 1'b1, 1'b0, '0);
    send_item(OP_TICK, 16'd0, 1'b1, 1'b0, '0);

    in_valid <= 1'b0;
    while (motor_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d commands and ticks under %0d register settings; %0d results checked.",
             items_sent, settings, results_seen);
    $display("Driver failure injected at the %s; %0d mismatches.", path_name, mismatches);
    if (mismatches == 0 && motor_reports.size() == 0) begin
      $display("PASS motor_soft_start_ramp_controller");
    end else begin
      $display("FAIL motor_soft_start_ramp_controller");
    end
    $finish;
  end

endmodule
